// File: hw/rtl/bounded_list_engine_assert.svh
// assertion macros shared by the list engine rtl
`ifndef BOUNDED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BLE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("list engine check failed (same cycle)");

// next-cycle implication, checked on every rising clock edge outside reset
`define BLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("list engine check failed (next cycle)");

`endif

// File: hw/rtl/ble_pkg.sv
// shared field widths, operation codes and error codes of the list engine
package ble_pkg;

   // request and response field widths
   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 8;
   localparam int DATA_W  = 32;
   localparam int COUNT_W = 8;
   localparam int ERR_W   = 2;

   typedef logic [MODE_W-1:0] mode_type;
   typedef logic [ERR_W-1:0]  err_type;

   // operation codes
   localparam mode_type MODE_PUSH_FRONT = 3'd0;
   localparam mode_type MODE_PUSH_BACK  = 3'd1;
   localparam mode_type MODE_POP_FRONT  = 3'd2;
   localparam mode_type MODE_READ       = 3'd3;
   localparam mode_type MODE_TAKE       = 3'd4;
   localparam mode_type MODE_DROP       = 3'd5;

   // error codes
   localparam err_type ERR_OK    = 2'd0;
   localparam err_type ERR_FULL  = 2'd1;
   localparam err_type ERR_EMPTY = 2'd2;
   localparam err_type ERR_RANGE = 2'd3;

endpackage

// File: hw/rtl/ble_req_if.sv
// request channel of the list engine: valid, ready and the request fields
interface ble_req_if;
   logic                          valid;
   logic                          ready;
   logic [ble_pkg::MODE_W-1:0]    mode;
   logic [ble_pkg::VALUE_W-1:0]   value;
   logic [ble_pkg::POS_W-1:0]     position;

   modport source (output valid, output mode, output value, output position, input ready);
   modport sink (input valid, input mode, input value, input position, output ready);
endinterface

// File: hw/rtl/ble_rsp_if.sv
// response channel of the list engine: valid, ready and the response fields
interface ble_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ble_pkg::DATA_W-1:0]    data;
   logic [ble_pkg::COUNT_W-1:0]   count;
   logic                          empty_flag;
   logic [ble_pkg::ERR_W-1:0]     error;

   modport source (output valid, output data, output count, output empty_flag, output error,
                   input ready);
   modport sink (input valid, input data, input count, input empty_flag, input error,
                 output ready);
endinterface

// File: hw/rtl/bounded_list_engine.sv
// bounded list kept as a ring buffer in one synchronous memory
//
// Usage: each request on req_ch asks for one list operation (push front,
// push back, pop front, read at a position, take the first n, drop the
// first n). Every request yields exactly one response on rsp_ch with the
// read data or the front element, the new length, an empty flag and an
// error code. Both channels move an item when valid and ready are high.
// An accepted request moves the engine to its result state, and the response
// register loads from there once it is free. No request is taken until the
// result state is left, set by the single memory access per request (read
// issued at the accept edge, data loaded in the result state into the
// response register). Pushed values on the slot being read are forwarded.
// Reset (synchronous, active high) empties the list at once: front pointer
// and length clear, the element memory is not cleared and needs no pass.
// When the receiver stalls, the response waits in the output register; one
// more request is still taken and then holds in its result cycle until the
// output register frees up.
module bounded_list_engine #(
   parameter int DEPTH      = 128,
   parameter int ELEM_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   ble_req_if.sink    req_ch,
   ble_rsp_if.source  rsp_ch
);

   `include "bounded_list_engine_assert.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > ble_pkg::POS_W) ? CNT_W : ble_pkg::POS_W;
   localparam int SUM_W = CMP_W + 1;

   localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_RESULT = 1'b1;

   // element memory
   logic [ELEM_WIDTH-1:0] mem [DEPTH];

   logic                    state_ff, state_in;
   logic [PTR_W-1:0]        front_ff, front_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    accept, out_free, load;
   logic                    full, empty;
   logic [CMP_W-1:0]        n_ext, cnt_ext, offset;
   logic [SUM_W-1:0]        sum_raw;
   logic [PTR_W-1:0]        slot, front_dec, rd_addr, wr_addr;
   logic                    wr_en, fwd_in, have_read_in;
   ble_pkg::err_type        err_in;
   logic [ELEM_WIDTH-1:0]   elem_value, rd_data_ff, fwd_val_ff, result_elem;
   logic                    fwd_ff, have_read_ff;
   ble_pkg::err_type        err_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ble_pkg::DATA_W-1:0]  rsp_data_ff;
   logic [ble_pkg::COUNT_W-1:0] rsp_count_ff;
   logic                    rsp_empty_ff;
   ble_pkg::err_type        rsp_err_ff;

   // handshake
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign load         = (state_ff == ST_RESULT) && out_free;

   assign full       = (count_ff == DEPTH_CNT);
   assign empty      = (count_ff == '0);
   assign elem_value = ELEM_WIDTH'(req_ch.value);
   assign n_ext      = CMP_W'(req_ch.position);
   assign cnt_ext    = CMP_W'(count_ff);

   // offset into the ring for the one slot adder
   always_comb begin
      case (req_ch.mode)
         ble_pkg::MODE_POP_FRONT: offset = CMP_W'(1);
         ble_pkg::MODE_PUSH_BACK: offset = cnt_ext;
         default:                 offset = n_ext;
      endcase
   end

   // slot = (front + offset) mod depth, valid while the sum stays below twice the depth
   assign sum_raw   = SUM_W'(front_ff) + SUM_W'(offset);
   assign slot      = (sum_raw >= DEPTH_SUM) ? PTR_W'(sum_raw - DEPTH_SUM) : PTR_W'(sum_raw);
   assign front_dec = (front_ff == '0) ? LAST_SLOT : front_ff - PTR_W'(1);

   // operation decoder
   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      err_in       = ble_pkg::ERR_OK;
      wr_en        = 1'b0;
      wr_addr      = slot;
      fwd_in       = 1'b0;
      have_read_in = 1'b0;
      unique case (req_ch.mode)
         ble_pkg::MODE_PUSH_FRONT: begin
            if (full) begin
               err_in = ble_pkg::ERR_FULL;
            end else begin
               front_in = front_dec;
               wr_en    = 1'b1;
               wr_addr  = front_dec;
               count_in = count_ff + CNT_W'(1);
               fwd_in   = 1'b1;
            end
         end
         ble_pkg::MODE_PUSH_BACK: begin
            if (full) begin
               err_in = ble_pkg::ERR_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               // the new element is also the front when the list was empty
               fwd_in   = empty;
            end
         end
         ble_pkg::MODE_POP_FRONT: begin
            if (empty) begin
               err_in = ble_pkg::ERR_EMPTY;
            end else begin
               front_in = slot;
               count_in = count_ff - CNT_W'(1);
            end
         end
         ble_pkg::MODE_READ: begin
            if (n_ext >= cnt_ext) begin
               err_in = ble_pkg::ERR_RANGE;
            end else begin
               have_read_in = 1'b1;
            end
         end
         ble_pkg::MODE_TAKE: begin
            if (n_ext < cnt_ext) begin
               count_in = CNT_W'(n_ext);
            end
         end
         ble_pkg::MODE_DROP: begin
            if (n_ext > cnt_ext) begin
               count_in = '0;
            end else begin
               front_in = slot;
               count_in = count_ff - CNT_W'(n_ext);
            end
         end
         default: begin
         end
      endcase
   end

   assign rd_addr = have_read_in ? slot : front_in;

   // memory write and registered read, both at the accept edge
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         mem[wr_addr] <= elem_value;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // sequencer
   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = accept ? ST_RESULT : ST_IDLE;
         ST_RESULT: state_in = out_free ? ST_IDLE : ST_RESULT;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   // per-request result info
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff       <= err_in;
         fwd_ff       <= fwd_in;
         fwd_val_ff   <= elem_value;
         have_read_ff <= have_read_in;
      end
   end

   // response data: read element, else front element, zero when empty
   always_comb begin
      if (have_read_ff || (count_ff != '0)) begin
         result_elem = fwd_ff ? fwd_val_ff : rd_data_ff;
      end else begin
         result_elem = '0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff  <= ble_pkg::DATA_W'(result_elem);
         rsp_count_ff <= ble_pkg::COUNT_W'(count_ff);
         rsp_empty_ff <= (count_ff == '0);
         rsp_err_ff   <= err_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.data       = rsp_data_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.empty_flag = rsp_empty_ff;
   assign rsp_ch.error      = rsp_err_ff;

   // checks
   `BLE_ASSERT_NEXT(a_error_keeps_list, accept && (err_in != ble_pkg::ERR_OK), (count_ff == $past(count_ff)) && (front_ff == $past(front_ff)))
   `BLE_ASSERT_NEXT(a_accept_to_result, accept, (state_ff == ST_RESULT) && !req_ch.ready)
   `BLE_ASSERT_NEXT(a_result_loaded, load, rsp_valid_ff)
   `BLE_ASSERT_SAME(a_count_bound, state_ff == ST_RESULT, count_ff <= DEPTH_CNT)

endmodule
